@@ src/uvst_pkg.sv @@
package uvst_pkg;

    localparam int CAPACITY = 16;
    localparam int VAL_W    = 32;
    localparam int SUM_W    = 36;
    localparam int CMD_W    = 2;
    localparam int POS_W    = 4;
    localparam int CNT_OW   = 5;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } t_state;

    // per-cell control from the sequencer
    typedef struct packed {
        logic cmp_en;
        logic valid;
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

@@ src/uvst_cell.sv @@
module uvst_cell (
    input  logic                          i_clk,
    input  uvst_pkg::t_cell_ctl           i_ctl,
    input  logic [uvst_pkg::VAL_W-1:0]    i_value,
    input  logic [uvst_pkg::VAL_W-1:0]    i_next,
    output logic [uvst_pkg::VAL_W-1:0]    o_entry,
    output logic                          o_match
);

    logic [uvst_pkg::VAL_W-1:0] r_entry;
    logic [uvst_pkg::VAL_W-1:0] n_entry;
    logic                       r_match;
    logic                       n_match;

    always_comb begin
        n_match = r_match;
        if (i_ctl.cmp_en) begin
            n_match = i_ctl.valid && (r_entry == i_value);
        end
    end

    // shift pulls the upper neighbor down, load takes the new value
    always_comb begin
        priority if (i_ctl.shift) begin
            n_entry = i_next;
        end else if (i_ctl.load) begin
            n_entry = i_value;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_match <= n_match;
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

@@ src/unique_value_set_table.sv @@
// ordered set of distinct signed 32-bit values, one command per transaction
//
// input channel: i_in_valid / o_in_stall with i_command and i_value
//   add appends an absent value, remove deletes it and closes the gap,
//   check (and the unused command code) only looks the value up
// output channel: o_out_valid / i_out_stall with o_found, o_position,
//   o_rejected_full, o_entry_count and o_total
//
// a row of cells holds the entries; every cell compares its entry with the
// incoming value in the accept cycle and registers the match bit
// the update state encodes the first match, shifts the cells above it down
// on a remove, or loads the next free cell on an add, and writes the result
// no new transaction is taken until the update of the current one has
// written its result and the sequencer is back in idle
// the result sits in its own register, so a new transaction is taken while
// an earlier result is still stalled; the update waits only if the output
// register is full and stalled
// synchronous reset empties the table (count and total to zero); entry
// contents are not cleared since only entries below the count are read
module unique_value_set_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [uvst_pkg::CMD_W-1:0]          i_command,
    input  logic signed [uvst_pkg::VAL_W-1:0]   i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_found,
    output logic [uvst_pkg::POS_W-1:0]          o_position,
    output logic                                o_rejected_full,
    output logic [uvst_pkg::CNT_OW-1:0]         o_entry_count,
    output logic signed [uvst_pkg::SUM_W-1:0]   o_total
);

    localparam int N = uvst_pkg::CAPACITY;

    uvst_pkg::t_state r_state, n_state;

    logic [uvst_pkg::CMD_W-1:0] r_cmd;
    logic [uvst_pkg::VAL_W-1:0] r_val;
    logic [uvst_pkg::CNT_W-1:0] r_count, n_count;
    logic [uvst_pkg::SUM_W-1:0] r_sum, n_sum;

    logic                        r_out_valid, n_out_valid;
    logic                        r_found;
    logic [uvst_pkg::POS_W-1:0]  r_position;
    logic                        r_rejected;
    logic [uvst_pkg::CNT_OW-1:0] r_count_out;
    logic [uvst_pkg::SUM_W-1:0]  r_total;

    logic                        in_accept;
    logic                        out_free;
    logic                        commit;
    logic                        hit;
    logic [uvst_pkg::IDX_W-1:0]  where;
    logic                        do_add;
    logic                        do_remove;
    logic                        full;
    logic [uvst_pkg::SUM_W-1:0]  val_ext;
    logic [uvst_pkg::VAL_W-1:0]  cell_value;

    logic [uvst_pkg::VAL_W-1:0]  w_entry [N];
    logic [N-1:0]                w_match;
    uvst_pkg::t_cell_ctl         w_ctl [N];

    // handshake
    assign o_in_stall = (r_state != uvst_pkg::ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign commit     = (r_state == uvst_pkg::ST_UPDATE) && out_free;

    // compare against the port value at accept, write the held value later
    assign cell_value = (r_state == uvst_pkg::ST_IDLE) ? i_value : r_val;

    // lowest matching cell; values are distinct so at most one is set
    always_comb begin
        where = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                where = uvst_pkg::IDX_W'(i);
            end
        end
    end

    assign hit       = |w_match;
    assign full      = (r_count >= uvst_pkg::CNT_W'(N));
    assign do_add    = commit && (r_cmd == uvst_pkg::CMD_ADD) && !hit && !full;
    assign do_remove = commit && (r_cmd == uvst_pkg::CMD_REMOVE) && hit;
    assign val_ext   = {{(uvst_pkg::SUM_W - uvst_pkg::VAL_W){r_val[uvst_pkg::VAL_W-1]}}, r_val};

    // cell row
    for (genvar g = 0; g < N; g++) begin : g_cell
        always_comb begin
            w_ctl[g].cmp_en = in_accept;
            w_ctl[g].valid  = (uvst_pkg::CNT_W'(g) < r_count);
            w_ctl[g].load   = do_add && (uvst_pkg::CNT_W'(g) == r_count);
            w_ctl[g].shift  = do_remove && (uvst_pkg::IDX_W'(g) >= where);
        end

        if (g == N - 1) begin : g_last
            uvst_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl[g]),
                .i_value (cell_value),
                .i_next  (w_entry[g]),
                .o_entry (w_entry[g]),
                .o_match (w_match[g])
            );
        end else begin : g_mid
            uvst_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl[g]),
                .i_value (cell_value),
                .i_next  (w_entry[g+1]),
                .o_entry (w_entry[g]),
                .o_match (w_match[g])
            );
        end
    end

    // sequencer: next state, count and sum
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_sum       = r_sum;
        n_out_valid = r_out_valid;
        if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            uvst_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = uvst_pkg::ST_UPDATE;
                end
            end
            uvst_pkg::ST_UPDATE: begin
                if (commit) begin
                    n_state     = uvst_pkg::ST_IDLE;
                    n_out_valid = 1'b1;
                    if (do_add) begin
                        n_count = r_count + 1'b1;
                        n_sum   = r_sum + val_ext;
                    end else if (do_remove) begin
                        n_count = r_count - 1'b1;
                        n_sum   = r_sum - val_ext;
                    end
                end
            end
            default: n_state = uvst_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= uvst_pkg::ST_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    // held transaction and result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd <= i_command;
            r_val <= i_value;
        end
        if (commit) begin
            r_found     <= hit;
            r_position  <= hit ? uvst_pkg::POS_W'(where) : '0;
            r_rejected  <= (r_cmd == uvst_pkg::CMD_ADD) && !hit && full;
            r_count_out <= uvst_pkg::CNT_OW'(n_count);
            r_total     <= n_sum;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_found         = r_found;
    assign o_position      = r_position;
    assign o_rejected_full = r_rejected;
    assign o_entry_count   = r_count_out;
    assign o_total         = r_total;

endmodule

@@ tb/unique_value_set_table_chk.sv @@
`timescale 1ns / 100ps

module unique_value_set_table_chk (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic [uvst_pkg::CMD_W-1:0]          i_command,
    input  logic signed [uvst_pkg::VAL_W-1:0]   i_value,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic                                i_found,
    input  logic [uvst_pkg::POS_W-1:0]          i_position,
    input  logic                                i_rejected_full,
    input  logic [uvst_pkg::CNT_OW-1:0]         i_entry_count,
    input  logic signed [uvst_pkg::SUM_W-1:0]   i_total,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    typedef struct packed {
        logic                               found;
        logic [uvst_pkg::POS_W-1:0]         position;
        logic                               rejected_full;
        logic [uvst_pkg::CNT_OW-1:0]        entry_count;
        logic signed [uvst_pkg::SUM_W-1:0]  total;
    } t_set_result;

    typedef struct {
        logic [uvst_pkg::CMD_W-1:0] cmd;
        logic [uvst_pkg::VAL_W-1:0] val;
        t_set_result                res;
    } t_lookup;

    // shadow copy of the table
    logic [uvst_pkg::VAL_W-1:0]         slots [uvst_pkg::CAPACITY];
    int                                 held;
    logic signed [uvst_pkg::SUM_W-1:0]  running_total;

    t_lookup expected_results [$];

    initial begin
        held          = 0;
        running_total = '0;
        o_fail_count  = 0;
        o_pending     = 0;
    end

    function automatic t_set_result apply_set_command(
        input logic [uvst_pkg::CMD_W-1:0] cmd,
        input logic [uvst_pkg::VAL_W-1:0] val
    );
        t_set_result r;
        int          hit_idx;
        int          i;
        hit_idx = -1;
        for (i = 0; i < held; i++) begin
            if (hit_idx < 0 && slots[i] == val)
                hit_idx = i;
        end
        r = '0;
        r.found    = (hit_idx >= 0);
        r.position = r.found ? hit_idx[uvst_pkg::POS_W-1:0] : '0;
        case (cmd)
            uvst_pkg::CMD_ADD: begin
                if (!r.found) begin
                    if (held < uvst_pkg::CAPACITY) begin
                        slots[held]   = val;
                        held          = held + 1;
                        running_total = running_total + {{4{val[31]}}, val};
                    end else begin
                        r.rejected_full = 1'b1;
                    end
                end
            end
            uvst_pkg::CMD_REMOVE: begin
                if (r.found) begin
                    // close the gap, order is kept
                    for (i = hit_idx; i < held - 1; i++)
                        slots[i] = slots[i + 1];
                    held          = held - 1;
                    running_total = running_total - {{4{val[31]}}, val};
                end
            end
            default: ;  // check and the spare code only look up
        endcase
        r.entry_count = held[uvst_pkg::CNT_OW-1:0];
        r.total       = running_total;
        return r;
    endfunction

    task automatic log_mismatch(input string what);
        if (o_fail_count < 10)
            $display("%0t mismatch: %s", $time, what);
        o_fail_count = o_fail_count + 1;
    endtask

    always @(posedge i_clk) begin
        t_lookup     head;
        t_lookup     req;
        t_set_result got;
        if (!i_rst_n) begin
            held          = 0;
            running_total = '0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got.found         = i_found;
                got.position      = i_position;
                got.rejected_full = i_rejected_full;
                got.entry_count   = i_entry_count;
                got.total         = i_total;
                if (expected_results.size() == 0) begin
                    log_mismatch($sformatf(
                        "unexpected result found %0b pos %0d full %0b count %0d total %0d",
                        got.found, got.position, got.rejected_full, got.entry_count,
                        got.total));
                end else begin
                    head = expected_results.pop_front();
                    if (got.found !== head.res.found
                            || got.position !== head.res.position
                            || got.rejected_full !== head.res.rejected_full
                            || got.entry_count !== head.res.entry_count
                            || got.total !== head.res.total) begin
                        log_mismatch($sformatf({"cmd %0d value %0d: expected found %0b ",
                            "pos %0d full %0b count %0d total %0d, got found %0b pos %0d ",
                            "full %0b count %0d total %0d"},
                            head.cmd, $signed(head.val), head.res.found, head.res.position,
                            head.res.rejected_full, head.res.entry_count, head.res.total,
                            got.found, got.position, got.rejected_full, got.entry_count,
                            got.total));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                req.cmd = i_command;
                req.val = i_value;
                req.res = apply_set_command(i_command, i_value);
                expected_results.push_back(req);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

@@ tb/tb_unique_value_set_table.sv @@
`timescale 1ns / 100ps

module tb_unique_value_set_table;

    // command code the block does not name; it must act as a check
    localparam logic [uvst_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 1650;
    localparam int PHASE_LEN    = 150;   // items per random phase
    localparam int POOL_SIZE    = 20;    // a bit above capacity so the table fills
    localparam int STUCK_LIMIT  = 2000;  // cycles with no transaction on either side
    localparam int DRAIN_CYCLES = 12;    // quiet time after the last result

    // flavor of the value pool used by one random phase
    typedef enum int {
        POOL_ANY,
        POOL_HIGH,
        POOL_LOW,
        POOL_NEAR_ZERO
    } t_pool_kind;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               i_in_valid;
    logic                               o_in_stall;
    logic [uvst_pkg::CMD_W-1:0]         i_command;
    logic signed [uvst_pkg::VAL_W-1:0]  i_value;
    logic                               o_out_valid;
    logic                               i_out_stall;
    logic                               o_found;
    logic [uvst_pkg::POS_W-1:0]         o_position;
    logic                               o_rejected_full;
    logic [uvst_pkg::CNT_OW-1:0]        o_entry_count;
    logic signed [uvst_pkg::SUM_W-1:0]  o_total;

    int   fail_count;
    int   pending;
    int   stuck_cycles = 0;
    logic burst_mode   = 1'b0;   // when set neither side idles

    logic in_fire;
    logic out_fire;

    assign in_fire  = i_in_valid && !o_in_stall;
    assign out_fire = o_out_valid && !i_out_stall;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    unique_value_set_table dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_found         (o_found),
        .o_position      (o_position),
        .o_rejected_full (o_rejected_full),
        .o_entry_count   (o_entry_count),
        .o_total         (o_total)
    );

    unique_value_set_table_chk u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_value         (i_value),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_found         (o_found),
        .i_position      (o_position),
        .i_rejected_full (o_rejected_full),
        .i_entry_count   (o_entry_count),
        .i_total         (o_total),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // watchdog: any transaction on either side restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || in_fire || out_fire)
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("tb_unique_value_set_table NOT OK");
        $finish;
    end

    // one input transaction; called right after a falling edge and returns
    // right after the falling edge that follows acceptance
    task automatic send_command(
        input logic [uvst_pkg::CMD_W-1:0] cmd,
        input logic [uvst_pkg::VAL_W-1:0] val
    );
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        // valid that stays high across items is only ever re-set high here
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_value    <= val;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // result side: stall a random number of cycles before each result,
    // then take it as soon as it shows up
    initial begin
        int hold;
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            hold = burst_mode ? 0 : $urandom_range(0, 8);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    initial begin
        logic [uvst_pkg::VAL_W-1:0] value_pool [POOL_SIZE];
        t_pool_kind                 kind;
        logic [uvst_pkg::CMD_W-1:0] cmd;
        logic [uvst_pkg::VAL_W-1:0] val;
        int                         add_pct;
        int                         remove_pct;
        int                         roll;
        int                         small_val;
        int                         k;
        int                         n;

        // every input known from time zero
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_command  <= uvst_pkg::CMD_CHECK;
        i_value    <= '0;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- directed part ----
        // value extremes of both signs
        send_command(uvst_pkg::CMD_ADD, 32'h8000_0000);
        send_command(uvst_pkg::CMD_ADD, 32'h7FFF_FFFF);
        send_command(uvst_pkg::CMD_ADD, 32'h0000_0000);
        send_command(uvst_pkg::CMD_ADD, 32'hFFFF_FFFF);
        // add of a value already held changes nothing
        send_command(uvst_pkg::CMD_ADD, 32'h7FFF_FFFF);
        send_command(uvst_pkg::CMD_CHECK, 32'hFFFF_FFFF);
        // spare command code behaves as a check
        send_command(CMD_SPARE, 32'h0000_0000);
        // remove of an absent value changes nothing
        send_command(uvst_pkg::CMD_REMOVE, 32'h0000_0005);
        // remove from the middle, later entries move down
        send_command(uvst_pkg::CMD_REMOVE, 32'h7FFF_FFFF);
        send_command(uvst_pkg::CMD_CHECK, 32'hFFFF_FFFF);
        // fill the table to capacity with distinct patterns
        for (k = 1; k <= 13; k++)
            send_command(uvst_pkg::CMD_ADD, k * 32'h1111_1111);
        // absent value into a full table is dropped
        send_command(uvst_pkg::CMD_ADD, 32'h0000_0001);
        // remove first and last entries
        send_command(uvst_pkg::CMD_REMOVE, 32'h8000_0000);
        send_command(uvst_pkg::CMD_REMOVE, 32'hDDDD_DDDD);

        // ---- random part ----
        // each phase works on a small pool so hits, removes of held values
        // and a full table are common; the mix of adds and removes shifts
        // from phase to phase to sweep the count up and down
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_LEN == 0) begin
                kind       = t_pool_kind'($urandom_range(0, 3));
                add_pct    = $urandom_range(25, 80);
                remove_pct = $urandom_range(10, 95 - add_pct);
                burst_mode = ($urandom_range(0, 3) == 0);
                for (k = 0; k < POOL_SIZE; k++) begin
                    case (kind)
                        POOL_HIGH:      value_pool[k] = 32'h7FFF_FFFF - $urandom_range(0, 31);
                        POOL_LOW:       value_pool[k] = 32'h8000_0000 + $urandom_range(0, 31);
                        POOL_NEAR_ZERO: begin
                            small_val     = int'($urandom_range(0, 20)) - 10;
                            value_pool[k] = small_val;
                        end
                        default:        value_pool[k] = $urandom;
                    endcase
                end
            end

            // mostly pool values, some fully random ones as noise
            if ($urandom_range(0, 9) == 0)
                val = $urandom;
            else
                val = value_pool[$urandom_range(0, POOL_SIZE - 1)];

            roll = $urandom_range(0, 99);
            if (roll < add_pct)
                cmd = uvst_pkg::CMD_ADD;
            else if (roll < add_pct + remove_pct)
                cmd = uvst_pkg::CMD_REMOVE;
            else if (roll < 96)
                cmd = uvst_pkg::CMD_CHECK;
            else
                cmd = CMD_SPARE;

            send_command(cmd, val);
        end

        i_in_valid <= 1'b0;
        burst_mode = 1'b0;

        // drain: every expected result in, then a few quiet cycles to catch
        // anything extra
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("tb_unique_value_set_table OK");
        else
            $display("tb_unique_value_set_table NOT OK");
        $finish;
    end

endmodule

@@ filelist.f @@
src/uvst_pkg.sv
src/uvst_cell.sv
src/unique_value_set_table.sv
tb/unique_value_set_table_chk.sv
tb/tb_unique_value_set_table.sv
